FILE: hdl/tjb_pkg.sv
// tjb_pkg: shared word types, status codes and reset constants of the jitter buffer
`timescale 1ns / 1ps
package tjb_pkg;

  localparam int TIME_BITS   = 62;
  localparam int HANDLE_BITS = 8;
  localparam int LIMIT_BITS  = 7;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd50;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_LATE      = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FLUSHED   = 3'd3;
  localparam logic [2:0] ST_PLAYED    = 3'd4;
  localparam logic [2:0] ST_MISSING   = 3'd5;
  localparam logic [2:0] ST_RELEASED  = 3'd6;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] time_sec;
    logic [29:0] time_nsec;
    logic [7:0]  packet_handle;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] handle_out;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]   etime;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

endpackage

FILE: hdl/tjb_mem.sv
// tjb_mem: entry store, one write and one registered read port
`timescale 1ns / 1ps
module tjb_mem
  import tjb_pkg::*;
#(
  parameter int DEPTH = 63,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/tjb_ctrl.sv
// tjb_ctrl: sequencer that walks, shifts, releases and plays entries of the ring store
`timescale 1ns / 1ps
module tjb_ctrl
  import tjb_pkg::*;
#(
  parameter int DEPTH = 63,
  parameter int AW    = 6,
  parameter int CW    = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  in_word_t              in_data,
  output logic                  in_stall,
  output logic                  out_valid,
  output out_word_t             out_data,
  input  logic                  out_stall,
  input  logic [LIMIT_BITS-1:0] search_limit,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output entry_t                wr_data,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  entry_t                rd_data
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_LATE_RD  = 15'h0002,
    S_LATE_CMP = 15'h0004,
    S_WALK     = 15'h0008,
    S_WALK_CMP = 15'h0010,
    S_PLACE    = 15'h0020,
    S_SH_RD    = 15'h0040,
    S_SH_WR    = 15'h0080,
    S_FL_RD    = 15'h0100,
    S_FL_EM    = 15'h0200,
    S_FL_END   = 15'h0400,
    S_TK_RD    = 15'h0800,
    S_TK_CMP   = 15'h1000,
    S_FIN      = 15'h2000,
    S_SPARE    = 15'h4000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          head_r, head_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          pos_r, pos_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic [TIME_BITS-1:0]   last_r, last_nxt;
  logic [TIME_BITS-1:0]   t_r;
  logic [HANDLE_BITS-1:0] h_r;
  logic [2:0]             fin_st_r, fin_st_nxt;
  logic [HANDLE_BITS-1:0] fin_h_r, fin_h_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_data_r, out_data_nxt;

  logic                   out_free;
  logic [LIMIT_BITS-1:0]  lim_m1;
  logic [AW-1:0]          head_inc;
  logic                   e_lt, e_eq;

  // logical position to ring address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] l);
    logic [AW:0] s;
    s = (AW+1)'(hd) + (AW+1)'(l);
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign lim_m1   = (search_limit == '0) ? '0 : search_limit - 1'b1;
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign e_lt     = rd_data.etime < t_r;
  assign e_eq     = rd_data.etime == t_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    fin_st_nxt    = fin_st_r;
    fin_h_nxt     = fin_h_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = phys(head_r, idx_r);
    wr_data       = rd_data;
    rd_en         = 1'b0;
    rd_addr       = phys(head_r, '0);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt   = '0;
          state_nxt = (in_data.req_type == REQ_TICK) ? S_TK_RD : S_LATE_RD;
        end
      end
      S_LATE_RD: begin
        if (count_r == '0) begin
          state_nxt = S_WALK;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_LATE_CMP;
        end
      end
      S_LATE_CMP: begin
        if (e_lt == 1'b0 && !e_eq && t_r <= last_r) begin
          fin_st_nxt = ST_LATE;
          fin_h_nxt  = h_r;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (LIMIT_BITS'(pos_r) == lim_m1) begin
          idx_nxt   = '0;
          state_nxt = S_FL_RD;
        end else if (pos_r >= count_r) begin
          state_nxt = S_PLACE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = phys(head_r, pos_r);
          state_nxt = S_WALK_CMP;
        end
      end
      S_WALK_CMP: begin
        if (e_lt) begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_WALK;
        end else if (e_eq) begin
          fin_st_nxt = ST_DUPLICATE;
          fin_h_nxt  = h_r;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        idx_nxt = count_r;
        if (count_r >= CW'(DEPTH)) begin
          idx_nxt   = '0;
          state_nxt = S_FL_RD;
        end else begin
          state_nxt = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (idx_r == pos_r) begin
          wr_en      = 1'b1;
          wr_addr    = phys(head_r, pos_r);
          wr_data    = '{etime: t_r, handle: h_r};
          count_nxt  = count_r + 1'b1;
          fin_st_nxt = ST_INSERTED;
          fin_h_nxt  = h_r;
          state_nxt  = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = phys(head_r, idx_r - 1'b1);
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        wr_en     = 1'b1;
        wr_addr   = phys(head_r, idx_r);
        idx_nxt   = idx_r - 1'b1;
        state_nxt = S_SH_RD;
      end
      S_FL_RD: begin
        if (idx_r == count_r) begin
          state_nxt = S_FL_END;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = phys(head_r, idx_r);
          state_nxt = S_FL_EM;
        end
      end
      S_FL_EM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_RELEASED, handle_out: rd_data.handle, last_of_run: 1'b0};
          idx_nxt       = idx_r + 1'b1;
          state_nxt     = S_FL_RD;
        end
      end
      S_FL_END: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = '{etime: t_r, handle: h_r};
        head_nxt   = '0;
        count_nxt  = CW'(1);
        fin_st_nxt = ST_FLUSHED;
        fin_h_nxt  = h_r;
        state_nxt  = S_FIN;
      end
      S_TK_RD: begin
        if (count_r == '0) begin
          fin_st_nxt = ST_MISSING;
          fin_h_nxt  = '0;
          state_nxt  = S_FIN;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_TK_CMP;
        end
      end
      S_TK_CMP: begin
        if (e_eq) begin
          head_nxt   = head_inc;
          count_nxt  = count_r - 1'b1;
          last_nxt   = t_r;
          fin_st_nxt = ST_PLAYED;
          fin_h_nxt  = rd_data.handle;
          state_nxt  = S_FIN;
        end else if (!e_lt) begin
          fin_st_nxt = ST_MISSING;
          fin_h_nxt  = '0;
          state_nxt  = S_FIN;
        end else if (out_free) begin
          // older than the tick: release and look at the next head
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_RELEASED, handle_out: rd_data.handle, last_of_run: 1'b0};
          head_nxt      = head_inc;
          count_nxt     = count_r - 1'b1;
          state_nxt     = S_TK_RD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: fin_st_r, handle_out: fin_h_r, last_of_run: 1'b1};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    fin_st_r   <= fin_st_nxt;
    fin_h_r    <= fin_h_nxt;
    out_data_r <= out_data_nxt;
    if (state_r == S_IDLE && in_valid) begin
      t_r <= {in_data.time_sec, in_data.time_nsec};
      h_r <= in_data.packet_handle;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hdl/timestamp_jitter_buffer.sv
// timestamp_jitter_buffer: top level, limit register, ring store and sequencer
//
//   channel  dir  handshake          word
//   in_      in   in_valid/in_stall  in_word_t (req_type, time, packet_handle)
//   out_     out  out_valid/out_stall out_word_t (status, handle_out, last_of_run)
//   cfg_     in   cfg_we             search_limit, 7 bits
//
// one word at a time; a tick releases head entries older than its time, then plays an
// equal one or reports missing; an insert drops a late or duplicate word, else walks
// to its place and shifts later entries up; the search limit or a full store flushes all
// synchronous reset empties the store and clears last played time, no clearing pass
// out_stall only holds the output register; entries in flight wait for it
`timescale 1ns / 1ps
module timestamp_jitter_buffer
  import tjb_pkg::*;
#(
  parameter int BUFFER_DEPTH = 63
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  in_word_t              in_data,
  output logic                  in_stall,
  output logic                  out_valid,
  output out_word_t             out_data,
  input  logic                  out_stall,
  input  logic                  cfg_we,
  input  logic [LIMIT_BITS-1:0] cfg_wdata
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  logic [LIMIT_BITS-1:0] limit_r;
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  entry_t                wr_data, rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  tjb_mem #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tjb_ctrl #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data      (in_data),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .out_stall    (out_stall),
    .search_limit (limit_r),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

endmodule
